>>> hw/rtl/hslbp_pkg.sv
// Package with the shared constants and types of the hybrid branch predictor.
package hslbp_pkg;

    localparam int LOCAL_HIST_BITS_DEF = 10;
    localparam int GHIST_W = 12;
    localparam int BANK_W = 9;
    localparam int GRP_W = 3;
    localparam int VOTE_ADDR_W = GRP_W + BANK_W;
    localparam int VOTE_DEPTH = 1 << VOTE_ADDR_W;
    localparam int SET_W = 9;
    localparam int SET_DEPTH = 1 << SET_W;
    localparam int WAY_W = 3;
    localparam int CHOOSER_W = 9;
    localparam int CHOOSER_DEPTH = 1 << CHOOSER_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [2:0] VOTE_MAX = 3'd5;
    localparam logic [2:0] VOTE_INIT = 3'd2;
    localparam logic [2:0] VOTE_THRESH = 3'd2;
    localparam logic [1:0] CTR2_MAX = 2'd3;
    localparam logic [1:0] CTR2_INIT = 2'd1;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [6:0] {
        ST_CLR  = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_V0   = 7'b0000100,
        ST_V1R  = 7'b0001000,
        ST_V1   = 7'b0010000,
        ST_V2R  = 7'b0100000,
        ST_V2   = 7'b1000000
    } state_t;

endpackage

>>> hw/rtl/hslbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hslbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hybrid_skewed_local_branch_predictor.sv
// Top level of the hybrid skewed-vote and local branch predictor.
//
// The input channel (s_) carries one item per branch event: s_tuser is the
// function (0 predict, 1 update) and s_tdata holds the address and, for an
// update, the resolved direction. The result channel (m_) returns one item
// with the predicted direction for every predict item; an update item
// returns nothing.
// An item is accepted in the idle state and then passes through the states
// V0, V1R, V1, V2R and V2, set by the single port pair of the vote counter
// memory, which reads and writes the three skewed bank entries one after
// another. A prediction is written to the output register in V2, and the
// next item can be accepted once the block is back in idle, so the block
// takes no new item before it is through with the last one.
// After reset the block clears its memories in one pass that writes the
// initial value to every entry, during which s_tready stays low.
// When the receiver stalls, the finished result holds in the output
// register and the block still accepts and works on the next item; a second
// prediction waits in its last step until the output register is free.
module hybrid_skewed_local_branch_predictor #(
    parameter int LOCAL_HIST_BITS = hslbp_pkg::LOCAL_HIST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: pc[31:0], resolved_taken[32], zero fill.
    input  logic [hslbp_pkg::S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: func[0].
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: prediction[0], zero fill.
    output logic [hslbp_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int LC_W = hslbp_pkg::WAY_W + LOCAL_HIST_BITS;
    localparam int LC_DEPTH = 1 << LC_W;
    localparam int CLR_W = (LC_W > hslbp_pkg::VOTE_ADDR_W) ? LC_W : hslbp_pkg::VOTE_ADDR_W;
    localparam int VA_W = hslbp_pkg::VOTE_ADDR_W;

    hslbp_pkg::state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic func_reg, func_next;
    logic taken_reg, taken_next;
    logic [31:0] pc_reg, pc_next;
    logic [VA_W-1:0] slot1_reg, slot1_next, slot2_reg, slot2_next;
    logic [VA_W-1:0] slot0_reg, slot0_next;
    logic [LOCAL_HIST_BITS-1:0] lhist_reg, lhist_next;
    logic [1:0] chooser_reg, chooser_next;
    logic [1:0] lctr_reg, lctr_next;
    logic [1:0] vcnt_reg, vcnt_next;
    logic [hslbp_pkg::GHIST_W-1:0] ghist_reg, ghist_next;
    logic last_vote_reg, last_vote_next, last_local_reg, last_local_next;
    logic m_valid_reg, m_valid_next, m_pred_reg, m_pred_next;

    logic [31:0] x_w, y_w;
    logic [hslbp_pkg::BANK_W-1:0] ia_w, ib_w, ic_w;
    logic [hslbp_pkg::GRP_W-1:0] grp_w;

    logic vt_we, vt_re;
    logic [VA_W-1:0] vt_waddr, vt_raddr;
    logic [2:0] vt_wdata, vt_rdata, vt_sat;
    logic lh_we, lh_re;
    logic [hslbp_pkg::SET_W-1:0] lh_waddr, lh_raddr;
    logic [LOCAL_HIST_BITS-1:0] lh_wdata, lh_rdata;
    logic lc_we, lc_re;
    logic [LC_W-1:0] lc_waddr, lc_raddr;
    logic [1:0] lc_wdata, lc_rdata, lc_sat;
    logic ch_we, ch_re;
    logic [hslbp_pkg::CHOOSER_W-1:0] ch_waddr, ch_raddr;
    logic [1:0] ch_wdata, ch_rdata, ch_new;

    logic s_fire, upd, vote_bit, vote_pred, local_pred, out_free;
    logic local_ok, vote_ok;

    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == hslbp_pkg::ST_IDLE);
    assign upd = (func_reg == hslbp_pkg::FUNC_UPDATE);
    assign out_free = !m_valid_reg || m_tready;

    assign x_w = (s_tdata[31:0] >> 2) ^ {20'd0, ghist_reg};
    assign y_w = (s_tdata[31:0] >> 3) ^ {20'd0, ghist_reg};
    assign ia_w = y_w[9:1] ^ {8'd0, x_w[0]};
    assign ib_w = {y_w[7:0], x_w[12]};
    assign ic_w = ia_w ^ ib_w;
    assign grp_w = ghist_reg[2:0] ^ s_tdata[18:16];

    assign vote_bit = (vt_rdata > hslbp_pkg::VOTE_THRESH);
    assign vote_pred = ({1'b0, vcnt_reg} + {2'd0, vote_bit}) >= 3'd2;
    assign local_pred = (lctr_reg > 2'd1);

    always_comb begin
        if (taken_reg) begin
            vt_sat = (vt_rdata < hslbp_pkg::VOTE_MAX) ? 3'(vt_rdata + 3'd1) : hslbp_pkg::VOTE_MAX;
            lc_sat = (lctr_reg < hslbp_pkg::CTR2_MAX) ? 2'(lctr_reg + 2'd1) : lctr_reg;
        end else begin
            vt_sat = (vt_rdata > 3'd0) ? 3'(vt_rdata - 3'd1) : 3'd0;
            lc_sat = (lctr_reg > 2'd0) ? 2'(lctr_reg - 2'd1) : 2'd0;
        end
        local_ok = (taken_reg == last_local_reg);
        vote_ok = (taken_reg == last_vote_reg);
        ch_new = chooser_reg;
        if (local_ok && !vote_ok && chooser_reg < hslbp_pkg::CTR2_MAX) begin
            ch_new = 2'(chooser_reg + 2'd1);
        end else if (!local_ok && vote_ok && chooser_reg > 2'd0) begin
            ch_new = 2'(chooser_reg - 2'd1);
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        func_next = func_reg;
        taken_next = taken_reg;
        pc_next = pc_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        slot2_next = slot2_reg;
        lhist_next = lhist_reg;
        chooser_next = chooser_reg;
        lctr_next = lctr_reg;
        vcnt_next = vcnt_reg;
        ghist_next = ghist_reg;
        last_vote_next = last_vote_reg;
        last_local_next = last_local_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        m_pred_next = m_pred_reg;

        vt_we = 1'b0;
        vt_waddr = slot0_reg;
        vt_wdata = vt_sat;
        vt_re = 1'b0;
        vt_raddr = {grp_w, ia_w};
        lh_we = 1'b0;
        lh_waddr = pc_reg[11:3];
        lh_wdata = {lhist_reg[LOCAL_HIST_BITS-2:0], taken_reg};
        lh_re = 1'b0;
        lh_raddr = s_tdata[11:3];
        lc_we = 1'b0;
        lc_waddr = {pc_reg[2:0], lhist_reg};
        lc_wdata = lc_sat;
        lc_re = 1'b0;
        lc_raddr = {pc_reg[2:0], lh_rdata};
        ch_we = 1'b0;
        ch_waddr = pc_reg[8:0];
        ch_wdata = ch_new;
        ch_re = 1'b0;
        ch_raddr = s_tdata[8:0];

        case (state_reg)
            hslbp_pkg::ST_CLR: begin
                vt_we = 1'b1;
                vt_waddr = clr_reg[VA_W-1:0];
                vt_wdata = hslbp_pkg::VOTE_INIT;
                lh_we = 1'b1;
                lh_waddr = clr_reg[hslbp_pkg::SET_W-1:0];
                lh_wdata = '0;
                lc_we = 1'b1;
                lc_waddr = clr_reg[LC_W-1:0];
                lc_wdata = hslbp_pkg::CTR2_INIT;
                ch_we = 1'b1;
                ch_waddr = clr_reg[hslbp_pkg::CHOOSER_W-1:0];
                ch_wdata = hslbp_pkg::CTR2_INIT;
                clr_next = CLR_W'(clr_reg + 1'b1);
                if (clr_reg == {CLR_W{1'b1}}) begin
                    state_next = hslbp_pkg::ST_IDLE;
                end
            end
            hslbp_pkg::ST_IDLE: begin
                if (s_fire) begin
                    func_next = s_tuser;
                    taken_next = s_tdata[32];
                    pc_next = s_tdata[31:0];
                    slot0_next = {grp_w, ia_w};
                    slot1_next = {grp_w, ib_w};
                    slot2_next = {grp_w, ic_w};
                    vt_re = 1'b1;
                    lh_re = 1'b1;
                    ch_re = 1'b1;
                    state_next = hslbp_pkg::ST_V0;
                end
            end
            hslbp_pkg::ST_V0: begin
                lhist_next = lh_rdata;
                chooser_next = ch_rdata;
                vcnt_next = {1'b0, vote_bit};
                vt_we = upd;
                vt_waddr = slot0_reg;
                lc_re = 1'b1;
                state_next = hslbp_pkg::ST_V1R;
            end
            hslbp_pkg::ST_V1R: begin
                lctr_next = lc_rdata;
                vt_re = 1'b1;
                vt_raddr = slot1_reg;
                state_next = hslbp_pkg::ST_V1;
            end
            hslbp_pkg::ST_V1: begin
                vcnt_next = 2'(vcnt_reg + {1'b0, vote_bit});
                vt_we = upd;
                vt_waddr = slot1_reg;
                state_next = hslbp_pkg::ST_V2R;
            end
            hslbp_pkg::ST_V2R: begin
                vt_re = 1'b1;
                vt_raddr = slot2_reg;
                state_next = hslbp_pkg::ST_V2;
            end
            hslbp_pkg::ST_V2: begin
                if (upd) begin
                    vt_we = 1'b1;
                    vt_waddr = slot2_reg;
                    lc_we = 1'b1;
                    lh_we = 1'b1;
                    ch_we = 1'b1;
                    ghist_next = {ghist_reg[hslbp_pkg::GHIST_W-2:0], taken_reg};
                    state_next = hslbp_pkg::ST_IDLE;
                end else if (out_free) begin
                    last_vote_next = vote_pred;
                    last_local_next = local_pred;
                    m_valid_next = 1'b1;
                    m_pred_next = (chooser_reg >= 2'd2) ? local_pred : vote_pred;
                    state_next = hslbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hslbp_pkg::ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hslbp_pkg::ST_CLR;
            clr_reg <= '0;
            ghist_reg <= '0;
            last_vote_reg <= 1'b1;
            last_local_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ghist_reg <= ghist_next;
            last_vote_reg <= last_vote_next;
            last_local_reg <= last_local_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg <= func_next;
        taken_reg <= taken_next;
        pc_reg <= pc_next;
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        slot2_reg <= slot2_next;
        lhist_reg <= lhist_next;
        chooser_reg <= chooser_next;
        lctr_reg <= lctr_next;
        vcnt_reg <= vcnt_next;
        m_pred_reg <= m_pred_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {{(hslbp_pkg::M_DATA_W-1){1'b0}}, m_pred_reg};

    hslbp_ram #(.WIDTH(3), .DEPTH(hslbp_pkg::VOTE_DEPTH)) u_vote_ram (
        .aclk(aclk), .we(vt_we), .waddr(vt_waddr), .wdata(vt_wdata),
        .re(vt_re), .raddr(vt_raddr), .rdata(vt_rdata)
    );

    hslbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(hslbp_pkg::SET_DEPTH)) u_lhist_ram (
        .aclk(aclk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .re(lh_re), .raddr(lh_raddr), .rdata(lh_rdata)
    );

    hslbp_ram #(.WIDTH(2), .DEPTH(LC_DEPTH)) u_lctr_ram (
        .aclk(aclk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
        .re(lc_re), .raddr(lc_raddr), .rdata(lc_rdata)
    );

    hslbp_ram #(.WIDTH(2), .DEPTH(hslbp_pkg::CHOOSER_DEPTH)) u_chooser_ram (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .re(ch_re), .raddr(ch_raddr), .rdata(ch_rdata)
    );

endmodule

>>> hw/rtl/hslbp_checker.sv
// Port-level checker for the hybrid branch predictor, bound to its top level.
module hslbp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hslbp_pkg::M_DATA_W-1:0] m_tdata
);

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("Block is ready or shows a result right after reset.");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed.");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[hslbp_pkg::M_DATA_W-1:1] == '0)
        else $error("Fill bits of the result are not zero.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Block accepted a second item before finishing the first.");

    a_update_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == hslbp_pkg::FUNC_UPDATE && !m_tvalid
        |=> !m_tvalid)
        else $error("Update item produced a result.");

endmodule

bind hybrid_skewed_local_branch_predictor hslbp_checker u_hslbp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> tb/tb_hybrid_skewed_local_branch_predictor.sv
// Self-checking testbench for the hybrid skewed-vote and local branch predictor.
`timescale 1ns / 100ps

module tb_hybrid_skewed_local_branch_predictor;
    import hslbp_pkg::*;

    localparam int LHB = LOCAL_HIST_BITS_DEF;
    localparam int N_RANDOM = 1400;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        func;
        logic [31:0] pc;
        logic        taken;
    } branch_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    hybrid_skewed_local_branch_predictor u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [GHIST_W-1:0] ghist;
    logic [2:0] vote_ctr [VOTE_DEPTH];
    logic [LHB-1:0] lhist [SET_DEPTH];
    logic [1:0] local_ctr [8 << LHB];
    logic [1:0] chooser [CHOOSER_DEPTH];
    logic last_vote, last_local;

    branch_item_t pending_items[$];
    logic expected_preds[$];
    int errors = 0;
    int n_pred = 0;
    int n_upd = 0;
    longint cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit hold_sender = 1'b0;
    bit stim_done = 1'b0;

    initial forever #1 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic vote_index(input logic [31:0] pc, output int idx [3]);
        logic [31:0] g, x, y, ia, ib, ic, grp;
        g = 32'(ghist);
        x = (pc >> 2) ^ g;
        y = (pc >> 3) ^ g;
        ia = (((y >> 1) | (x & 32'h2000)) ^ (x & 32'h1)) & 32'h1ff;
        ib = (((y << 1) & 32'h3fff) | ((x >> 12) & 32'h1)) & 32'h1ff;
        ic = (ia ^ ib) & 32'h1ff;
        grp = (g ^ (pc >> 16)) & 32'h7;
        idx[0] = int'(grp * 512 + ia);
        idx[1] = int'(grp * 512 + ib);
        idx[2] = int'(grp * 512 + ic);
    endtask

    task automatic predictor_step(input branch_item_t it);
        int idx [3];
        int set, lslot, cslot, votes;
        set = int'(it.pc[11:3]);
        lslot = int'({it.pc[2:0], lhist[set]});
        cslot = int'(it.pc[8:0]);
        votes = 0;
        vote_index(it.pc, idx);
        if (it.func == FUNC_PREDICT) begin
            for (int i = 0; i < 3; i++) if (vote_ctr[idx[i]] > VOTE_THRESH) votes++;
            last_vote = (votes >= 2);
            last_local = (local_ctr[lslot] > 2'd1);
            expected_preds.push_back(chooser[cslot] >= 2'd2 ? last_local : last_vote);
            n_pred++;
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (it.taken && vote_ctr[idx[i]] < VOTE_MAX) vote_ctr[idx[i]]++;
                else if (!it.taken && vote_ctr[idx[i]] > 0) vote_ctr[idx[i]]--;
            end
            ghist = {ghist[GHIST_W-2:0], it.taken};
            if (it.taken && local_ctr[lslot] < CTR2_MAX) local_ctr[lslot]++;
            else if (!it.taken && local_ctr[lslot] > 0) local_ctr[lslot]--;
            lhist[set] = {lhist[set][LHB-2:0], it.taken};
            if (it.taken == last_local && it.taken != last_vote) begin
                if (chooser[cslot] < CTR2_MAX) chooser[cslot]++;
            end else if (it.taken != last_local && it.taken == last_vote) begin
                if (chooser[cslot] > 0) chooser[cslot]--;
            end
            n_upd++;
        end
    endtask

    function automatic branch_item_t mk(input logic f, input logic [31:0] pc, input logic t);
        branch_item_t it;
        it.func = f;
        it.pc = pc;
        it.taken = t;
        return it;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predictor_step(mk(s_tuser, s_tdata[31:0], s_tdata[32]));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 && !hold_sender) begin
                    branch_item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= it.func;
                    s_tdata <= {7'd0, it.taken, it.pc};
                    send_gap <= gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_preds.size() == 0) begin
                    $error("unexpected prediction item: prediction=%0d", m_tdata[0]);
                    errors++;
                end else begin
                    logic e;
                    e = expected_preds.pop_front();
                    if (m_tdata[0] !== e || m_tdata[M_DATA_W-1:1] !== '0) begin
                        $error("prediction mismatch: expected %0d, actual %0d", e, m_tdata);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_sequence(input logic [31:0] pc);
        int n;
        logic t;
        n = $urandom_range(1, 6);
        t = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
            pending_items.push_back(mk(FUNC_PREDICT, pc, 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 4) == 0) t = ~t;
            pending_items.push_back(mk(FUNC_UPDATE, pc, t));
        end
    endtask

    initial begin
        logic [31:0] hot_pcs [16];
        ghist = '0;
        last_vote = 1'b1;
        last_local = 1'b1;
        foreach (vote_ctr[i]) vote_ctr[i] = VOTE_INIT;
        foreach (lhist[i]) lhist[i] = '0;
        foreach (local_ctr[i]) local_ctr[i] = CTR2_INIT;
        foreach (chooser[i]) chooser[i] = CTR2_INIT;
        foreach (hot_pcs[i]) hot_pcs[i] = $urandom();

        // An update before any predict trains the chooser from reset predictions.
        pending_items.push_back(mk(FUNC_UPDATE, 32'h0, 1'b0));
        pending_items.push_back(mk(FUNC_PREDICT, 32'h0, 1'b0));
        pending_items.push_back(mk(FUNC_PREDICT, 32'hffff_ffff, 1'b1));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(mk(FUNC_UPDATE, 32'hffff_ffff, 1'b1));
        pending_items.push_back(mk(FUNC_PREDICT, 32'hffff_ffff, 1'b0));
        for (int i = 0; i < 8; i++)
            pending_items.push_back(mk(FUNC_UPDATE, 32'h0000_0000, 1'b0));
        pending_items.push_back(mk(FUNC_PREDICT, 32'h0000_0000, 1'b0));
        pending_items.push_back(mk(FUNC_PREDICT, 32'haaaa_5555, 1'b1));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < N_RANDOM; ) begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 7) begin
                add_sequence(hot_pcs[$urandom_range(0, 15)]);
            end else if (r < 9) begin
                add_sequence($urandom());
            end else begin
                pending_items.push_back(mk(1'($urandom_range(0, 1)), $urandom(),
                                           1'($urandom_range(0, 1))));
            end
            n = n_pred + n_upd + pending_items.size();
            if (n > N_RANDOM / 2 && !hold_sender && stim_done == 1'b0) begin
                // Let the block drain completely once mid-run.
                wait (pending_items.size() == 0);
                hold_sender = 1'b1;
                wait (expected_preds.size() == 0 && !s_tvalid);
                repeat (20) @(posedge aclk);
                hold_sender = 1'b0;
                stim_done = 1'b1;
            end
        end

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_preds.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Ran %0d predict and %0d update items, with saturation, aliasing and stalls.",
                 n_pred, n_upd);
        if (errors == 0 && expected_preds.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
